// ----- hdl/spcc_pkg.sv -----
// ----------------------------------------------------------------------------
// SATA port command controller package
// Shared types, codes and constants for the command controller.
// ----------------------------------------------------------------------------
package spcc_pkg;

    // Largest transfer that one command may carry, in sectors.
    localparam logic [7:0] MAX_SECTORS = 8'd128;

    // ATA command opcodes.
    localparam logic [7:0] OP_READ_DMA      = 8'hc8;
    localparam logic [7:0] OP_WRITE_DMA     = 8'hca;
    localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;

    // Register FIS and command header constants.
    localparam logic [7:0]  DEV_LBA_MODE  = 8'h40;
    localparam logic [6:0]  HDR_FIS_LEN   = 7'd5;
    localparam logic [31:0] IRQ_ERR_MASK  = 32'h7900_0000;
    localparam logic [7:0]  TFD_ERR_MASK  = 8'h21;

    typedef enum logic [1:0] {
        REQ_TRANSFER   = 2'd0,
        REQ_FLUSH      = 2'd1,
        REQ_PORT_IRQ   = 2'd2,
        REQ_COMPLETION = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OUT_NONE        = 3'd0,
        OUT_ISSUED      = 3'd1,
        OUT_REJECTED    = 3'd2,
        OUT_IRQ_DONE    = 3'd3,
        OUT_IRQ_ERROR   = 3'd4,
        OUT_IGNORED     = 3'd5,
        OUT_FINISH_OK   = 3'd6,
        OUT_FINISH_FAIL = 3'd7
    } t_outcome;

    typedef enum logic [1:0] {
        CFG_LONG_ADDR = 2'd0,
        CFG_CAPACITY  = 2'd1,
        CFG_FLUSH_OP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [48:0] wdata;
    } t_cfg_write;

    typedef struct packed {
        t_req        req_type;
        logic        write_access;
        logic [47:0] start_lba;
        logic [7:0]  sector_count;
        logic [31:0] irq_status;
        logic        slot_pending;
        logic [7:0]  task_file_status;
        logic [16:0] bytes_transferred;
    } t_item;

    typedef struct packed {
        t_outcome    outcome;
        logic [7:0]  opcode;
        logic [47:0] fis_lba;
        logic [7:0]  fis_device;
        logic [15:0] fis_count;
        logic [6:0]  header_flags;
        logic        prdt_present;
        logic [31:0] prdt_byte_field;
        logic [1:0]  port_state;
    } t_result;

endpackage

// ----- hdl/spcc_engine.sv -----
// ----------------------------------------------------------------------------
// SATA port command engine
// Holds the slot state and configuration, and decides one item per step.
// ----------------------------------------------------------------------------
module spcc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spcc_pkg::t_cfg_write i_cfg,
    input  logic                i_step,
    input  spcc_pkg::t_item     i_item,
    output spcc_pkg::t_result   o_result
);
    import spcc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_BUSY   = 2'd1,
        ST_DONE   = 2'd2,
        ST_FAILED = 2'd3
    } t_state;

    t_state      r_state, n_state;
    logic [16:0] r_expected_bytes, n_expected_bytes;
    logic [31:0] r_latched_irq, n_latched_irq;
    logic        r_long_addr;
    logic [48:0] r_capacity;
    logic [7:0]  r_flush_op;

    logic [48:0] lba_end;
    logic [16:0] xfer_bytes;
    logic        irq_err;
    t_result     res;

    assign lba_end    = {1'b0, i_item.start_lba} + {41'd0, i_item.sector_count};
    assign xfer_bytes = {i_item.sector_count, 9'd0};
    assign irq_err    = (i_item.irq_status & IRQ_ERR_MASK) != 32'd0;

    always_comb begin
        n_state          = r_state;
        n_expected_bytes = r_expected_bytes;
        n_latched_irq    = r_latched_irq;
        res              = '0;
        res.outcome      = OUT_NONE;
        case (i_item.req_type)
            REQ_TRANSFER: begin
                if (r_state != ST_IDLE || i_item.sector_count > MAX_SECTORS ||
                    lba_end > r_capacity) begin
                    res.outcome = OUT_REJECTED;
                end else if (i_item.sector_count != 8'd0) begin
                    res.outcome = OUT_ISSUED;
                    if (i_item.write_access) begin
                        res.opcode = r_long_addr ? OP_WRITE_DMA_EXT : OP_WRITE_DMA;
                    end else begin
                        res.opcode = r_long_addr ? OP_READ_DMA_EXT : OP_READ_DMA;
                    end
                    if (r_long_addr) begin
                        res.fis_lba    = i_item.start_lba;
                        res.fis_device = DEV_LBA_MODE;
                    end else begin
                        // Bits 27..24 of the address ride in the device byte.
                        res.fis_lba    = {24'd0, i_item.start_lba[23:0]};
                        res.fis_device = DEV_LBA_MODE | {4'd0, i_item.start_lba[27:24]};
                    end
                    res.fis_count       = {8'd0, i_item.sector_count};
                    res.header_flags    = HDR_FIS_LEN | {i_item.write_access, 6'd0};
                    res.prdt_present    = 1'b1;
                    res.prdt_byte_field = {1'b1, 14'd0, xfer_bytes - 17'd1};
                    n_state             = ST_BUSY;
                    n_expected_bytes    = xfer_bytes;
                    n_latched_irq       = 32'd0;
                end
            end
            REQ_FLUSH: begin
                if (r_state != ST_IDLE) begin
                    res.outcome = OUT_REJECTED;
                end else if (r_flush_op != 8'd0) begin
                    res.outcome      = OUT_ISSUED;
                    res.opcode       = r_flush_op;
                    res.header_flags = HDR_FIS_LEN;
                    n_state          = ST_BUSY;
                    n_expected_bytes = 17'd0;
                    n_latched_irq    = 32'd0;
                end
            end
            REQ_PORT_IRQ: begin
                if (r_state == ST_BUSY && (irq_err || !i_item.slot_pending)) begin
                    n_latched_irq = i_item.irq_status;
                    if (irq_err || (i_item.task_file_status & TFD_ERR_MASK) != 8'd0) begin
                        n_state     = ST_FAILED;
                        res.outcome = OUT_IRQ_ERROR;
                    end else begin
                        n_state     = ST_DONE;
                        res.outcome = OUT_IRQ_DONE;
                    end
                end else begin
                    res.outcome = OUT_IGNORED;
                end
            end
            REQ_COMPLETION: begin
                if (r_state == ST_DONE) begin
                    if (i_item.bytes_transferred == r_expected_bytes) begin
                        n_state     = ST_IDLE;
                        res.outcome = OUT_FINISH_OK;
                    end else begin
                        n_state     = ST_FAILED;
                        res.outcome = OUT_FINISH_FAIL;
                    end
                end else if (r_state == ST_FAILED) begin
                    res.outcome = OUT_FINISH_FAIL;
                end else begin
                    res.outcome = OUT_IGNORED;
                end
            end
            default: begin
                res.outcome = OUT_IGNORED;
            end
        endcase
        res.port_state = n_state;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_expected_bytes <= 17'd0;
            r_latched_irq    <= 32'd0;
            r_long_addr      <= 1'b0;
            r_capacity       <= 49'd0;
            r_flush_op       <= 8'd0;
        end else begin
            if (i_step) begin
                r_state          <= n_state;
                r_expected_bytes <= n_expected_bytes;
                r_latched_irq    <= n_latched_irq;
            end
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_LONG_ADDR: r_long_addr <= i_cfg.wdata[0];
                    CFG_CAPACITY:  r_capacity  <= i_cfg.wdata;
                    CFG_FLUSH_OP:  r_flush_op  <= i_cfg.wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // An issued command always leaves the slot busy.
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.outcome == OUT_ISSUED) |=> (r_state == ST_BUSY))
        else $error("issued command did not leave the slot busy");

    // Failure is sticky until reset.
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FAILED) |=> (r_state == ST_FAILED))
        else $error("failed state left without reset");

    // A classified interrupt keeps its status word.
    a_irq_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (res.outcome == OUT_IRQ_DONE || res.outcome == OUT_IRQ_ERROR))
        |=> (r_latched_irq == $past(i_item.irq_status)))
        else $error("interrupt status not latched");

    // Command fields are quiet unless a command goes out.
    a_fields_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.outcome != OUT_ISSUED) |-> (res.opcode == 8'd0 && res.prdt_present == 1'b0 &&
        res.header_flags == 7'd0))
        else $error("command fields set without an issued command");
`endif

endmodule

// ----- hdl/sata_port_command_controller_top.sv -----
// ----------------------------------------------------------------------------
// SATA port command controller
// Single-slot command issue and completion tracking for one SATA port.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Content
// s_axis    in   tvalid / tready      tuser: req_type; tdata: request fields
// m_axis    out  tvalid / tready      tuser: outcome; tdata: FIS and state
// cfg       in   we (no back-pressure) index 0 long_addressing, 1 capacity,
//                                     2 flush opcode
//
// An accepted item waits in the input register while the decision logic
// works on it, and the result register takes the outcome when the item
// advances. One item per cycle is sustained while the result side is not
// stalled; the slot state updates as an item moves from the input register
// to the result register, so the next item sees it.
// A stalled result holds in the result register while the input register
// keeps one more item; the input side stalls only when both are full.
// Reset is synchronous and active low; it empties both registers, returns
// the slot to idle and clears the configuration.
//
module sata_port_command_controller_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request items.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata from bit 0 up: write_access, start_lba[47:0], sector_count[7:0],
    // irq_status[31:0], slot_pending, task_file_status[7:0],
    // bytes_transferred[16:0], zero fill to 120 bits.
    input  logic [119:0] i_s_axis_tdata,
    // tuser: req_type[1:0].
    input  logic [1:0]   i_s_axis_tuser,
    // Result items.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata from bit 0 up: opcode[7:0], fis_lba[47:0], fis_device[7:0],
    // fis_count[15:0], header_flags[6:0], prdt_present,
    // prdt_byte_field[31:0], port_state[1:0], zero fill to 128 bits.
    output logic [127:0] o_m_axis_tdata,
    // tuser: outcome[2:0].
    output logic [2:0]   o_m_axis_tuser,
    // Configuration writes.
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [48:0]  i_cfg_wdata
);
    import spcc_pkg::*;

    logic        r_in_valid;
    t_item       r_in_item;
    t_item       in_item;
    logic        r_out_valid;
    t_result     r_out_result;
    t_result     result;
    t_cfg_write  cfg;
    logic        in_accept;
    logic        advance;

    // Unpack the request item from the stream.
    always_comb begin
        in_item.req_type          = t_req'(i_s_axis_tuser);
        in_item.write_access      = i_s_axis_tdata[0];
        in_item.start_lba         = i_s_axis_tdata[48:1];
        in_item.sector_count      = i_s_axis_tdata[56:49];
        in_item.irq_status        = i_s_axis_tdata[88:57];
        in_item.slot_pending      = i_s_axis_tdata[89];
        in_item.task_file_status  = i_s_axis_tdata[97:90];
        in_item.bytes_transferred = i_s_axis_tdata[114:98];
    end

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.wdata = i_cfg_wdata;

    // The held item moves on whenever the result register is free or
    // being emptied in this cycle.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    spcc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out_result <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_result.outcome;
    assign o_m_axis_tdata  = {6'd0,
                              r_out_result.port_state,
                              r_out_result.prdt_byte_field,
                              r_out_result.prdt_present,
                              r_out_result.header_flags,
                              r_out_result.fis_count,
                              r_out_result.fis_device,
                              r_out_result.fis_lba,
                              r_out_result.opcode};

endmodule
